// File: rtl/dhcp_opt_pkg.sv
// Shared types and constants for the DHCP option TLV parser.
// No dependencies; used by every module of the block.
package dhcp_opt_pkg;

  localparam int DNS_SLOTS_DEF = 4;
  localparam int MAX_DNS       = 4;     // address fields in one result
  localparam int STAGE_BYTES   = 16;
  localparam int RESULT_W      = 331;
  localparam int OUT_TDATA_W   = 336;

  localparam logic [7:0] OPT_PAD    = 8'd0;
  localparam logic [7:0] OPT_SUBNET = 8'd1;
  localparam logic [7:0] OPT_ROUTER = 8'd3;
  localparam logic [7:0] OPT_DNS    = 8'd6;
  localparam logic [7:0] OPT_LEASE  = 8'd51;
  localparam logic [7:0] OPT_MSGTYP = 8'd53;
  localparam logic [7:0] OPT_SERVER = 8'd54;
  localparam logic [7:0] OPT_RENEW  = 8'd58;
  localparam logic [7:0] OPT_REBIND = 8'd59;
  localparam logic [7:0] OPT_END    = 8'd255;

  typedef enum logic [3:0] {
    PH_CODE  = 4'b0001,
    PH_LEN   = 4'b0010,
    PH_VALUE = 4'b0100,
    PH_STOP  = 4'b1000
  } phase_t;

  // Byte 0 is the first value byte on the wire.
  typedef logic [STAGE_BYTES-1:0][7:0] stage_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] code;
    logic [7:0] len;
    stage_t     stage;
  } commit_t;

  // Packed LSB first: msg_kind lands in the low bits.
  typedef struct packed {
    logic [31:0]              server;
    logic [31:0]              rebind;
    logic [31:0]              renew;
    logic [31:0]              lease;
    logic [MAX_DNS-1:0][31:0] dns;
    logic [2:0]               dns_num;
    logic [31:0]              router;
    logic [31:0]              subnet;
    logic [7:0]               msg_kind;
  } result_t;

  // Four staged bytes as one word, first byte most significant.
  function automatic logic [31:0] stage_word(input stage_t s, input logic [1:0] slot);
    return {s[{slot, 2'd0}], s[{slot, 2'd1}], s[{slot, 2'd2}], s[{slot, 2'd3}]};
  endfunction

endpackage

// File: rtl/dhcp_opt_walker.sv
// Code/length/value walker: tracks the parse phase and stages value bytes.
// Depends on dhcp_opt_pkg.
module dhcp_opt_walker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic                  clear,
  input  logic [7:0]            data_byte,
  output dhcp_opt_pkg::commit_t commit
);

  dhcp_opt_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]           code_r, code_nxt;
  logic [7:0]           len_r, len_nxt;
  logic [7:0]           rem_r, rem_nxt;
  dhcp_opt_pkg::stage_t stage_r, stage_nxt;
  logic [7:0]           pos;

  assign pos = len_r - rem_r;

  always_comb begin
    phase_nxt    = phase_r;
    code_nxt     = code_r;
    len_nxt      = len_r;
    rem_nxt      = rem_r;
    stage_nxt    = stage_r;
    commit.valid = 1'b0;
    unique case (phase_r)
      dhcp_opt_pkg::PH_CODE: begin
        if (data_byte == dhcp_opt_pkg::OPT_END) begin
          phase_nxt = dhcp_opt_pkg::PH_STOP;
        end else if (data_byte != dhcp_opt_pkg::OPT_PAD) begin
          code_nxt  = data_byte;
          phase_nxt = dhcp_opt_pkg::PH_LEN;
        end
      end
      dhcp_opt_pkg::PH_LEN: begin
        len_nxt   = data_byte;
        rem_nxt   = data_byte;
        stage_nxt = '0;
        if (data_byte == 8'd0) begin
          commit.valid = 1'b1;
          phase_nxt    = dhcp_opt_pkg::PH_CODE;
        end else begin
          phase_nxt = dhcp_opt_pkg::PH_VALUE;
        end
      end
      dhcp_opt_pkg::PH_VALUE: begin
        if (pos[7:4] == 4'd0) begin
          stage_nxt[pos[3:0]] = data_byte;
        end
        rem_nxt = rem_r - 8'd1;
        if (rem_r == 8'd1) begin
          commit.valid = 1'b1;
          phase_nxt    = dhcp_opt_pkg::PH_CODE;
        end
      end
      dhcp_opt_pkg::PH_STOP: begin
        phase_nxt = dhcp_opt_pkg::PH_STOP;
      end
      default: begin
        phase_nxt = dhcp_opt_pkg::PH_CODE;
      end
    endcase
    commit.code  = code_r;
    commit.len   = len_nxt;
    commit.stage = stage_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= dhcp_opt_pkg::PH_CODE;
      code_r  <= '0;
      len_r   <= '0;
      rem_r   <= '0;
    end else if (step) begin
      if (clear) begin
        phase_r <= dhcp_opt_pkg::PH_CODE;
        code_r  <= '0;
        len_r   <= '0;
        rem_r   <= '0;
      end else begin
        phase_r <= phase_nxt;
        code_r  <= code_nxt;
        len_r   <= len_nxt;
        rem_r   <= rem_nxt;
      end
    end
  end

  // Cleared on every length byte before use.
  always_ff @(posedge clk) begin
    if (step) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

// File: rtl/dhcp_opt_capture.sv
// Captured option values; applies a finished option and clears after a result.
// Depends on dhcp_opt_pkg.
module dhcp_opt_capture #(
  parameter int DNS_SLOTS = dhcp_opt_pkg::DNS_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic                  clear,
  input  dhcp_opt_pkg::commit_t commit,
  output dhcp_opt_pkg::result_t result
);

  localparam int DNS_CAP = (DNS_SLOTS < dhcp_opt_pkg::MAX_DNS) ? DNS_SLOTS
                                                              : dhcp_opt_pkg::MAX_DNS;

  logic [7:0]  msg_r, msg_nxt;
  logic [31:0] subnet_r, subnet_nxt;
  logic [31:0] router_r, router_nxt;
  logic [31:0] lease_r, lease_nxt;
  logic [31:0] renew_r, renew_nxt;
  logic [31:0] rebind_r, rebind_nxt;
  logic [31:0] server_r, server_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [DNS_CAP-1:0][31:0] dns_r, dns_nxt;
  logic [2:0]  dns_n;
  logic        len4, is_dns;
  logic [31:0] word0;

  assign len4   = (commit.len == 8'd4);
  assign is_dns = commit.valid && (commit.code == dhcp_opt_pkg::OPT_DNS);
  assign word0  = dhcp_opt_pkg::stage_word(commit.stage, 2'd0);
  // length / 4, capped
  assign dns_n  = (commit.len[7:2] > 6'(DNS_CAP)) ? 3'(DNS_CAP) : 3'(commit.len[7:2]);

  always_comb begin
    msg_nxt    = msg_r;
    subnet_nxt = subnet_r;
    router_nxt = router_r;
    lease_nxt  = lease_r;
    renew_nxt  = renew_r;
    rebind_nxt = rebind_r;
    server_nxt = server_r;
    cnt_nxt    = is_dns ? dns_n : cnt_r;
    if (commit.valid) begin
      unique case (commit.code)
        dhcp_opt_pkg::OPT_MSGTYP: if (commit.len == 8'd1) msg_nxt = commit.stage[0];
        dhcp_opt_pkg::OPT_SUBNET: if (len4) subnet_nxt = word0;
        dhcp_opt_pkg::OPT_ROUTER: if (commit.len >= 8'd4) router_nxt = word0;
        dhcp_opt_pkg::OPT_LEASE:  if (len4) lease_nxt = word0;
        dhcp_opt_pkg::OPT_RENEW:  if (len4) renew_nxt = word0;
        dhcp_opt_pkg::OPT_REBIND: if (len4) rebind_nxt = word0;
        dhcp_opt_pkg::OPT_SERVER: if (len4) server_nxt = word0;
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < DNS_CAP; g++) begin : g_dns
    assign dns_nxt[g] = !is_dns ? dns_r[g] :
                        (3'(g) < dns_n) ? dhcp_opt_pkg::stage_word(commit.stage, 2'(g))
                                        : 32'd0;
  end

  for (genvar g = 0; g < dhcp_opt_pkg::MAX_DNS; g++) begin : g_out
    if (g < DNS_CAP) begin : g_live
      assign result.dns[g] = dns_nxt[g];
    end else begin : g_zero
      assign result.dns[g] = 32'd0;
    end
  end

  assign result.msg_kind = msg_nxt;
  assign result.subnet   = subnet_nxt;
  assign result.router   = router_nxt;
  assign result.dns_num  = cnt_nxt;
  assign result.lease    = lease_nxt;
  assign result.renew    = renew_nxt;
  assign result.rebind   = rebind_nxt;
  assign result.server   = server_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_r    <= '0;
      subnet_r <= '0;
      router_r <= '0;
      lease_r  <= '0;
      renew_r  <= '0;
      rebind_r <= '0;
      server_r <= '0;
      cnt_r    <= '0;
      dns_r    <= '0;
    end else if (step) begin
      if (clear) begin
        msg_r    <= '0;
        subnet_r <= '0;
        router_r <= '0;
        lease_r  <= '0;
        renew_r  <= '0;
        rebind_r <= '0;
        server_r <= '0;
        cnt_r    <= '0;
        dns_r    <= '0;
      end else begin
        msg_r    <= msg_nxt;
        subnet_r <= subnet_nxt;
        router_r <= router_nxt;
        lease_r  <= lease_nxt;
        renew_r  <= renew_nxt;
        rebind_r <= rebind_nxt;
        server_r <= server_nxt;
        cnt_r    <= cnt_nxt;
        dns_r    <= dns_nxt;
      end
    end
  end

endmodule

// File: rtl/dhcp_option_tlv_parser.sv
// Top level of the DHCP option TLV parser: input register, walker, capture, result register.
// Depends on dhcp_opt_pkg, dhcp_opt_walker and dhcp_opt_capture.
//
//  channel | direction | transaction
//  --------+-----------+-----------------------------------------------------
//  in_     | sink      | one options byte; tlast marks the last byte
//  out_    | source    | all captured values, one per area (on the last byte)
//
// Cycles: one byte per cycle sustained while no last byte is held. A byte is walked
// while it sits in the input register; the edge that retires it updates the captured
// values and, for a last byte, loads the result register at that same edge, so
// out_tvalid rises once the last byte is retired, when the result register is free.
// Reset: synchronous, active low; clears parse phase, captured values and
// both valid flags.
// Stalls: only a last byte whose result cannot enter a still-full output
// register waits; every other byte moves on regardless of out_tready.
module dhcp_option_tlv_parser #(
  parameter int DNS_SLOTS = dhcp_opt_pkg::DNS_SLOTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [7:0]                           in_tdata,  // [7:0] data_byte
  input  logic                                 in_tlast,  // last_byte
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [7:0] message_type, [39:8] netmask, [71:40] router_address,
  // [74:72] dns_num, [106:75] dns_first, [138:107] dns_second,
  // [170:139] dns_third, [202:171] dns_fourth, [234:203] lease_seconds,
  // [266:235] renewal_seconds, [298:267] rebinding_seconds,
  // [330:299] server_identifier, [335:331] zero
  output logic [dhcp_opt_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int DNS_CAP = (DNS_SLOTS < dhcp_opt_pkg::MAX_DNS) ? DNS_SLOTS
                                                              : dhcp_opt_pkg::MAX_DNS;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_data_r;
  logic       s1_last_r;
  // result register
  logic       out_valid_r;
  logic [dhcp_opt_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic                  advance;
  logic                  emit;
  dhcp_opt_pkg::commit_t commit;
  dhcp_opt_pkg::result_t result;

  // A non-last byte never needs the output register.
  assign advance   = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign emit      = advance && s1_last_r;
  assign in_tready = !s1_valid_r || advance;

  dhcp_opt_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .clear     (emit),
    .data_byte (s1_data_r),
    .commit    (commit)
  );

  dhcp_opt_capture #(
    .DNS_SLOTS (DNS_SLOTS)
  ) u_capture (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .clear  (emit),
    .commit (commit),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_data_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= {(dhcp_opt_pkg::OUT_TDATA_W - dhcp_opt_pkg::RESULT_W)'(0), result};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Input side only backs up behind a held last-byte result.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && s1_last_r && out_valid_r && !out_tready))
    else $error("input stalled without a pending result");

  // The result register takes exactly what the capture logic showed on the last byte.
  a_emit_load: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (out_valid_r && out_data_r[dhcp_opt_pkg::RESULT_W-1:0] == $past(result)))
    else $error("result register missed a completed area");

  // DNS count never exceeds the configured slots.
  a_dns_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[74:72] <= 3'(DNS_CAP)))
    else $error("DNS count above slot cap");

  // With a zero count, the first DNS slot reads zero.
  a_dns_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[74:72] == 3'd0) |-> (out_data_r[106:75] == 32'd0))
    else $error("stale DNS address with zero count");

endmodule

// File: dv/tb.sv
// Self-checking testbench for dhcp_option_tlv_parser: directed option areas, then random ones.
// Depends on dhcp_opt_pkg and the RTL top level; a local option walker predicts each result.
`timescale 1ns / 1ps

module tb;
  import dhcp_opt_pkg::*;

  localparam int DNS_CAP     = (DNS_SLOTS_DEF < MAX_DNS) ? DNS_SLOTS_DEF : MAX_DNS;
  localparam int ITEM_BUDGET = 650;   // no new area starts once this many bytes went in
  localparam int HOLD_OFF    = 200;   // one long receiver stall to back up the block
  localparam int STALL_LIMIT = 2000;  // cycles without any transaction before giving up
  localparam int DRAIN_WAIT  = 10;    // byte reg + walk + result reg, with margin

  // One row of the directed table. When typed is set on a last byte, the
  // result is the literal one here (message type and subnet, all else zero).
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        typed;
    logic [7:0]  msg;
    logic [31:0] subnet;
  } row_t;

  localparam int NDIR = 28;
  localparam row_t DIRECTED [NDIR] = '{
    // pad, msg type at its top value, subnet all ones, end code, junk byte last
    '{OPT_PAD,    1'b0, 1'b0, 8'h00, 32'h0},
    '{OPT_MSGTYP, 1'b0, 1'b0, 8'h00, 32'h0},
    '{8'd1,       1'b0, 1'b0, 8'h00, 32'h0},
    '{8'hFF,      1'b0, 1'b0, 8'h00, 32'h0},
    '{OPT_SUBNET, 1'b0, 1'b0, 8'h00, 32'h0},
    '{8'd4,       1'b0, 1'b0, 8'h00, 32'h0},
    '{8'hFF,      1'b0, 1'b0, 8'h00, 32'h0},
    '{8'hFF,      1'b0, 1'b0, 8'h00, 32'h0},
    '{8'hFF,      1'b0, 1'b0, 8'h00, 32'h0},
    '{8'hFF,      1'b0, 1'b0, 8'h00, 32'h0},
    '{OPT_END,    1'b0, 1'b0, 8'h00, 32'h0},
    '{8'h12,      1'b1, 1'b1, 8'hFF, 32'hFFFF_FFFF},
    // code byte marked last: no length, nothing committed
    '{OPT_ROUTER, 1'b1, 1'b1, 8'h00, 32'h0},
    // DNS of length 0, then a lease of length 255 cut short by the last byte
    '{OPT_DNS,    1'b0, 1'b0, 8'h00, 32'h0},
    '{8'd0,       1'b0, 1'b0, 8'h00, 32'h0},
    '{OPT_LEASE,  1'b0, 1'b0, 8'h00, 32'h0},
    '{8'd255,     1'b0, 1'b0, 8'h00, 32'h0},
    '{8'h01,      1'b0, 1'b0, 8'h00, 32'h0},
    '{8'h02,      1'b1, 1'b1, 8'h00, 32'h0},
    // lone pad marked last
    '{OPT_PAD,    1'b1, 1'b1, 8'h00, 32'h0},
    // rebinding time of length 0 is ignored
    '{OPT_REBIND, 1'b0, 1'b0, 8'h00, 32'h0},
    '{8'd0,       1'b1, 1'b1, 8'h00, 32'h0},
    // well-formed server id, left to the predictor
    '{OPT_SERVER, 1'b0, 1'b0, 8'h00, 32'h0},
    '{8'd4,       1'b0, 1'b0, 8'h00, 32'h0},
    '{8'hC0,      1'b0, 1'b0, 8'h00, 32'h0},
    '{8'hA8,      1'b0, 1'b0, 8'h00, 32'h0},
    '{8'h00,      1'b0, 1'b0, 8'h00, 32'h0},
    '{8'h01,      1'b1, 1'b0, 8'h00, 32'h0}
  };

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata   = '0;
  logic                   in_tlast   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  always #5 clk = ~clk;

  dhcp_option_tlv_parser DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // ---------------------------------------------------------------------
  // Option walker: tracks the parse and the captured values per area
  // ---------------------------------------------------------------------
  phase_t     walk_phase;
  logic [7:0] opt_code;
  logic [7:0] opt_len;
  logic [7:0] opt_left;
  stage_t     opt_bytes;    // value bytes, first on the wire at index 0
  result_t    captured;     // what the next result would report

  result_t    pending_reports[$];
  logic [8:0] area_q[$];    // {last, data} for one options area
  int         bytes_sent;
  int         reports_seen;
  int         mismatches;
  int         quiet_cycles;

  function automatic void clear_walker();
    walk_phase = PH_CODE;
    opt_code   = '0;
    opt_len    = '0;
    opt_left   = '0;
    opt_bytes  = '0;
    captured   = '0;
  endfunction

  // Staged bytes 4*slot..4*slot+3 as a word, first byte in the MSBs
  function automatic logic [31:0] word_at(input int slot);
    return {opt_bytes[slot*4], opt_bytes[slot*4+1], opt_bytes[slot*4+2], opt_bytes[slot*4+3]};
  endfunction

  // Apply a completed option; wrong lengths leave the captured value alone
  function automatic void commit_option();
    int n;
    case (opt_code)
      OPT_MSGTYP: if (opt_len == 8'd1) captured.msg_kind = opt_bytes[0];
      OPT_SUBNET: if (opt_len == 8'd4) captured.subnet = word_at(0);
      OPT_ROUTER: if (opt_len >= 8'd4) captured.router = word_at(0);
      OPT_DNS: begin
        n = opt_len / 4;
        if (n > DNS_CAP) n = DNS_CAP;
        for (int i = 0; i < MAX_DNS; i++) captured.dns[i] = (i < n) ? word_at(i) : 32'h0;
        captured.dns_num = 3'(n);
      end
      OPT_LEASE:  if (opt_len == 8'd4) captured.lease  = word_at(0);
      OPT_RENEW:  if (opt_len == 8'd4) captured.renew  = word_at(0);
      OPT_REBIND: if (opt_len == 8'd4) captured.rebind = word_at(0);
      OPT_SERVER: if (opt_len == 8'd4) captured.server = word_at(0);
      default: ;
    endcase
  endfunction

  // Walk one byte; returns 1 with the report when the byte closes the area
  function automatic bit walk_byte(input logic [7:0] b, input logic lst, output result_t rep);
    int pos;
    rep = '0;
    case (walk_phase)
      PH_CODE: begin
        if (b == OPT_END) walk_phase = PH_STOP;
        else if (b != OPT_PAD) begin
          opt_code   = b;
          walk_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        opt_len   = b;
        opt_left  = b;
        opt_bytes = '0;
        if (b == 8'd0) begin
          commit_option();
          walk_phase = PH_CODE;
        end else begin
          walk_phase = PH_VALUE;
        end
      end
      PH_VALUE: begin
        pos = opt_len - opt_left;
        if (pos < STAGE_BYTES) opt_bytes[pos] = b;   // longer values only skipped
        opt_left = opt_left - 8'd1;
        if (opt_left == 8'd0) begin
          commit_option();
          walk_phase = PH_CODE;
        end
      end
      default: ;   // stopped: ignore until the last byte
    endcase
    if (!lst) return 1'b0;
    rep = captured;
    clear_walker();   // next byte starts a fresh area
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Input side: one byte per transaction
  // ---------------------------------------------------------------------
  task automatic offer(input logic [7:0] b, input logic lst, input int gap,
                       input bit typed, input result_t typed_rep);
    result_t rep;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    if (walk_byte(b, lst, rep)) pending_reports.push_back(typed ? typed_rep : rep);
  endtask

  // Mostly the right length, sometimes anything in [lo, hi]
  function automatic int length_for(input int good, input int lo, input int hi);
    return ($urandom_range(0, 4) != 0) ? good : $urandom_range(lo, hi);
  endfunction

  // One random options area: mostly well-formed options with random values,
  // some noise, some ended by the end code, some cut off mid-option.
  task automatic build_area();
    int         len;
    int         cut;
    int         ending;
    logic [7:0] code;
    area_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) area_q.push_back({1'b0, 8'($urandom_range(0, 255))});
    end else begin
      repeat ($urandom_range(0, 4)) begin
        if ($urandom_range(0, 9) == 0) begin
          area_q.push_back({1'b0, OPT_PAD});
        end else begin
          case ($urandom_range(0, 9))
            0: begin code = OPT_MSGTYP; len = length_for(1, 0, 4); end
            1: begin code = OPT_SUBNET; len = length_for(4, 0, 8); end
            2: begin code = OPT_LEASE;  len = length_for(4, 0, 8); end
            3: begin code = OPT_RENEW;  len = length_for(4, 0, 8); end
            4: begin code = OPT_REBIND; len = length_for(4, 0, 8); end
            5: begin code = OPT_SERVER; len = length_for(4, 0, 8); end
            6: begin code = OPT_ROUTER; len = length_for(4, 0, 20); end
            7: begin code = 8'($urandom_range(1, 254)); len = $urandom_range(0, 10); end
            default: begin
              code = OPT_DNS;
              // a few values run past the 16 staged bytes
              len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 18);
            end
          endcase
          area_q.push_back({1'b0, code});
          area_q.push_back({1'b0, 8'(len)});
          repeat (len) area_q.push_back({1'b0, 8'($urandom_range(0, 255))});
        end
      end
      ending = $urandom_range(0, 9);
      if (ending < 2) begin
        area_q.push_back({1'b0, OPT_END});
        repeat ($urandom_range(0, 3)) area_q.push_back({1'b0, 8'($urandom_range(0, 255))});
      end else if (ending == 2 && area_q.size() > 1) begin
        cut = $urandom_range(1, area_q.size() - 1);
        while (area_q.size() > cut) void'(area_q.pop_back());
      end
    end
    if (area_q.size() == 0) area_q.push_back({1'b0, 8'($urandom_range(0, 255))});
    area_q[area_q.size()-1][8] = 1'b1;
  endtask

  // ---------------------------------------------------------------------
  // Output side: compare each result transaction with the oldest prediction
  // ---------------------------------------------------------------------
  function automatic void cmp_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] result %0d %s: expected %h, got %h", $time, reports_seen, name,
                 want, got);
    end
  endfunction

  task automatic check_report(input logic [OUT_TDATA_W-1:0] raw);
    result_t got;
    result_t want;
    got = result_t'(raw[RESULT_W-1:0]);
    reports_seen++;
    if (pending_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] result transaction with none pending, tdata=%h", $time, raw);
      return;
    end
    want = pending_reports.pop_front();
    cmp_field("message_type",      32'(want.msg_kind), 32'(got.msg_kind));
    cmp_field("netmask",           want.subnet,        got.subnet);
    cmp_field("router_address",    want.router,        got.router);
    cmp_field("dns_num",           32'(want.dns_num),  32'(got.dns_num));
    cmp_field("dns_first",         want.dns[0],        got.dns[0]);
    cmp_field("dns_second",        want.dns[1],        got.dns[1]);
    cmp_field("dns_third",         want.dns[2],        got.dns[2]);
    cmp_field("dns_fourth",        want.dns[3],        got.dns[3]);
    cmp_field("lease_seconds",     want.lease,         got.lease);
    cmp_field("renewal_seconds",   want.renew,         got.renew);
    cmp_field("rebinding_seconds", want.rebind,        got.rebind);
    cmp_field("server_identifier", want.server,        got.server);
    cmp_field("tdata padding",     32'h0,              32'(raw[OUT_TDATA_W-1:RESULT_W]));
  endtask

  // Receiver: random stalls per result, runs of none, and one long hold-off
  // while the sender keeps going so the output register fills and in_tready drops.
  initial begin : receiver
    int stall;
    bit rx_burst;
    rx_burst = 1'b0;
    wait (rst_n);
    forever begin
      if ($urandom_range(0, 7) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 9);
      if (reports_seen == 15) stall = HOLD_OFF;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      check_report(out_tdata);
    end
  end

  // Watchdog: a run of cycles with no transaction on either side is a hang
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    result_t typed_rep;
    bit      tx_burst;
    int      gap;
    bytes_sent   = 0;
    reports_seen = 0;
    mismatches   = 0;
    quiet_cycles = 0;
    tx_burst     = 1'b0;
    clear_walker();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (DIRECTED[i]) begin
      typed_rep          = '0;
      typed_rep.msg_kind = DIRECTED[i].msg;
      typed_rep.subnet   = DIRECTED[i].subnet;
      offer(DIRECTED[i].data, DIRECTED[i].last, $urandom_range(0, 9),
            DIRECTED[i].typed, typed_rep);
    end

    // random areas; some areas go through back to back
    while (bytes_sent < ITEM_BUDGET) begin
      build_area();
      tx_burst = ($urandom_range(0, 3) == 0);
      foreach (area_q[i]) begin
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        offer(area_q[i][7:0], area_q[i][8], gap, 1'b0, '0);
      end
    end
    in_tvalid <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (pending_reports.size() != 0) begin
      mismatches++;
      $display("%0d result transactions never arrived", pending_reports.size());
    end
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
